[sv/uds_transfer_data_framer_crc_assert.svh]
// assertion macros used by the framer output module uds_tdf_emit
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef UDS_TRANSFER_DATA_FRAMER_CRC_ASSERT_SVH
`define UDS_TRANSFER_DATA_FRAMER_CRC_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge outside reset
`define UDS_TDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("uds framer assertion failed");

// checked on every rising edge, reset included
`define UDS_TDF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("uds framer assertion failed");

`else

`define UDS_TDF_ASSERT(lbl, clk, rstn, prop)
`define UDS_TDF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[sv/uds_tdf_pkg.sv]
// shared constants, item record type and crc-32 byte update for the framer
// no dependencies
`timescale 1ns / 1ps

package uds_tdf_pkg;

  localparam logic [7:0]  SID_TRANSFER = 8'h36;
  localparam logic [7:0]  SID_EXIT     = 8'h37;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [11:0] HDR_BYTES    = 12'd2;
  localparam logic [11:0] MIN_BLOCK    = 12'd3;
  localparam logic [11:0] BLK_LEN_RST  = 12'd4095;
  localparam logic [7:0]  SEQ_INIT     = 8'd1;

  // one accepted item with everything the output side needs
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  seq;
    logic        hdr;
    logic        frm_end;
    logic        fin;
    logic [31:0] crc;
  } rec_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  byte_in);
    logic [31:0] c;
    c = crc_in ^ {24'd0, byte_in};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/uds_transfer_data_framer_crc.sv]
// Byte stream framer for UDS TransferData downloads with running image CRC-32 (no final XOR).
// Each accepted image byte leaves as one result, three when it opens a frame
// (0x36 and the sequence byte go first), and one more (the 0x37 exit frame with
// the finished CRC) when it is the last byte of the image. Unless out_tready stalls,
// the block takes one byte per cycle inside a frame and the single output register
// shows one result per cycle; a frame opening adds the 0x36 and sequence results and
// the image end the exit result. The maximum request length, written through
// cfg_wr_en/cfg_wr_data while idle by the user (not enforced), acts from the next byte.
// depends on uds_tdf_pkg, uds_tdf_core and uds_tdf_emit
`timescale 1ns / 1ps

module uds_transfer_data_framer_crc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,   // max request length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // data_byte
  input  logic        in_tlast,      // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,     // out_byte [7:0], crc_out [39:8]
  output logic        out_tlast,     // frame_last
  output logic [2:0]  out_tuser      // frame_first [0], crc_valid [1], run_end [2]
);
  import uds_tdf_pkg::*;

  logic        rec_valid;
  logic        rec_take;
  rec_t        rec;
  logic [7:0]  out_byte;
  logic        out_first;
  logic        out_last;
  logic [31:0] out_crc;
  logic        out_crc_valid;
  logic        out_run_end;

  uds_tdf_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_data     (in_tdata),
    .in_fin      (in_tlast),
    .rec_valid   (rec_valid),
    .rec         (rec),
    .rec_take    (rec_take)
  );

  uds_tdf_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (rec_valid),
    .rec           (rec),
    .rec_take      (rec_take),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_byte      (out_byte),
    .out_first     (out_first),
    .out_last      (out_last),
    .out_crc       (out_crc),
    .out_crc_valid (out_crc_valid),
    .out_run_end   (out_run_end)
  );

  assign out_tdata = {out_crc, out_byte};
  assign out_tlast = out_last;
  assign out_tuser = {out_run_end, out_crc_valid, out_first};

endmodule

[sv/uds_tdf_core.sv]
// input side: frame fill, sequence and crc state, builds one record per item
// depends on uds_tdf_pkg
`timescale 1ns / 1ps

module uds_tdf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [11:0]       cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_data,
  input  logic              in_fin,
  output logic              rec_valid,
  output uds_tdf_pkg::rec_t rec,
  input  logic              rec_take
);
  import uds_tdf_pkg::*;

  logic [11:0] blk_len_r;
  logic [11:0] fill_r, fill_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        rec_valid_r, rec_valid_nxt;
  rec_t        rec_r, rec_nxt;

  logic        accept;
  logic [11:0] len_eff;
  logic [11:0] chunk;
  logic [12:0] fill_inc;
  logic        frm_end;

  assign in_tready = !rec_valid_r || rec_take;
  assign accept    = in_tvalid && in_tready;
  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  always_comb begin
    len_eff  = (blk_len_r < MIN_BLOCK) ? MIN_BLOCK : blk_len_r;
    chunk    = len_eff - HDR_BYTES;
    fill_inc = {1'b0, fill_r} + 13'd1;
    frm_end  = in_fin || (fill_inc >= {1'b0, chunk});
    crc_nxt  = crc_byte(crc_r, in_data);

    rec_nxt.data    = in_data;
    rec_nxt.seq     = seq_r;
    rec_nxt.hdr     = (fill_r == 12'd0);
    rec_nxt.frm_end = frm_end;
    rec_nxt.fin     = in_fin;
    rec_nxt.crc     = crc_nxt;

    if (in_fin) begin
      fill_nxt = 12'd0;
      seq_nxt  = SEQ_INIT;
    end else if (frm_end) begin
      fill_nxt = 12'd0;
      seq_nxt  = seq_r + 8'd1;
    end else begin
      fill_nxt = fill_inc[11:0];
      seq_nxt  = seq_r;
    end

    if (accept) begin
      rec_valid_nxt = 1'b1;
    end else if (rec_take) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_len_r   <= BLK_LEN_RST;
      fill_r      <= 12'd0;
      seq_r       <= SEQ_INIT;
      crc_r       <= CRC_INIT;
      rec_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blk_len_r <= cfg_wr_data;
      end
      rec_valid_r <= rec_valid_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
        seq_r  <= seq_nxt;
        crc_r  <= in_fin ? CRC_INIT : crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

[sv/uds_tdf_emit.sv]
// output side: expands each record into sid, sequence, data and exit results
// depends on uds_tdf_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "uds_transfer_data_framer_crc_assert.svh"

module uds_tdf_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rec_valid,
  input  uds_tdf_pkg::rec_t rec,
  output logic              rec_take,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_byte,
  output logic              out_first,
  output logic              out_last,
  output logic [31:0]       out_crc,
  output logic              out_crc_valid,
  output logic              out_run_end
);
  import uds_tdf_pkg::*;

  typedef enum logic [1:0] {
    PH_SID,
    PH_SEQ,
    PH_DATA,
    PH_EXIT
  } phase_t;

  rec_t        cur_r;
  phase_t      phase_r;
  logic        pend_r;
  logic        out_tvalid_r;
  logic [7:0]  byte_r;
  logic        first_r, last_r, crc_valid_r, run_end_r;
  logic [31:0] crc_r;

  logic        out_load, go;
  rec_t        sel_rec;
  phase_t      sel_ph, ph_nxt;
  logic        pend_nxt;
  logic [7:0]  byte_nxt;
  logic        first_nxt, last_nxt, crc_valid_nxt, run_end_nxt;
  logic [31:0] crc_nxt;

  assign out_load = !out_tvalid_r || out_tready;
  assign rec_take = out_load && !pend_r && rec_valid;
  assign go       = out_load && (pend_r || rec_valid);

  always_comb begin
    sel_rec = pend_r ? cur_r : rec;
    if (pend_r) begin
      sel_ph = phase_r;
    end else begin
      sel_ph = rec.hdr ? PH_SID : PH_DATA;
    end

    byte_nxt      = sel_rec.data;
    first_nxt     = 1'b0;
    last_nxt      = 1'b0;
    crc_nxt       = 32'd0;
    crc_valid_nxt = 1'b0;
    run_end_nxt   = 1'b0;
    ph_nxt        = PH_DATA;
    pend_nxt      = 1'b0;

    case (sel_ph)
      PH_SID: begin
        byte_nxt  = SID_TRANSFER;
        first_nxt = 1'b1;
        ph_nxt    = PH_SEQ;
        pend_nxt  = 1'b1;
      end
      PH_SEQ: begin
        byte_nxt = sel_rec.seq;
        ph_nxt   = PH_DATA;
        pend_nxt = 1'b1;
      end
      PH_DATA: begin
        byte_nxt    = sel_rec.data;
        last_nxt    = sel_rec.frm_end;
        run_end_nxt = !sel_rec.fin;
        ph_nxt      = PH_EXIT;
        pend_nxt    = sel_rec.fin;
      end
      PH_EXIT: begin
        byte_nxt      = SID_EXIT;
        first_nxt     = 1'b1;
        last_nxt      = 1'b1;
        crc_nxt       = sel_rec.crc;
        crc_valid_nxt = 1'b1;
        run_end_nxt   = 1'b1;
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      pend_r       <= 1'b0;
      phase_r      <= PH_SID;
    end else if (go) begin
      out_tvalid_r <= 1'b1;
      pend_r       <= pend_nxt;
      phase_r      <= ph_nxt;
    end else if (out_load) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cur_r       <= sel_rec;
      byte_r      <= byte_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      crc_r       <= crc_nxt;
      crc_valid_r <= crc_valid_nxt;
      run_end_r   <= run_end_nxt;
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_byte      = byte_r;
  assign out_first     = first_r;
  assign out_last      = last_r;
  assign out_crc       = crc_r;
  assign out_crc_valid = crc_valid_r;
  assign out_run_end   = run_end_r;

  // exit result is a complete one-byte frame and ends the run
  `UDS_TDF_ASSERT(a_exit_shape, clk, rst_n, (out_tvalid_r && crc_valid_r) |-> (first_r && last_r && run_end_r && byte_r == SID_EXIT))
  // crc field stays zero away from the exit result
  `UDS_TDF_ASSERT(a_crc_zero, clk, rst_n, (out_tvalid_r && !crc_valid_r) |-> (crc_r == 32'd0))
  // a transfer frame start never closes the run
  `UDS_TDF_ASSERT(a_sid_open, clk, rst_n, (out_tvalid_r && first_r && !crc_valid_r) |-> (byte_r == SID_TRANSFER && !last_r && !run_end_r))
  // pending pieces are always shown, so the output cannot drop while work remains
  `UDS_TDF_ASSERT_ALWAYS(a_pend_shown, clk, (rst_n && pend_r) |-> out_tvalid_r)

endmodule

[dv/uds_transfer_data_framer_crc_chk.sv]
// checker for the transfer data framer: follows the config port and both item streams,
// predicts every frame byte and the image crc, and compares the results in order
// depends on uds_tdf_pkg for the service ids, block length limits and crc and sequence constants
`timescale 1ns / 1ps

module uds_transfer_data_framer_crc_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,   // max request length
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,      // data_byte
  input  logic        in_tlast,      // final_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,     // out_byte [7:0], crc_out [39:8]
  input  logic        out_tlast,     // frame_last
  input  logic [2:0]  out_tuser,     // frame_first [0], crc_valid [1], run_end [2]
  output int          fail_cnt,
  output int          pending
);
  import uds_tdf_pkg::*;

  typedef struct packed {
    logic [7:0]  octet;
    logic        frm_first;
    logic        frm_last;
    logic [31:0] crc;
    logic        crc_ok;
    logic        run_end;
  } frame_out_t;

  frame_out_t  frame_bytes_q[$];
  logic [11:0] blk_len;
  logic [11:0] blk_fill;
  logic [7:0]  seq_no;
  logic [31:0] img_crc;

  // reflected crc-32, one data bit per step
  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic frame_out_t mk_out(input logic [7:0] o, input logic f, input logic l,
                                        input logic [31:0] c, input logic ok);
    frame_out_t r;
    r.octet     = o;
    r.frm_first = f;
    r.frm_last  = l;
    r.crc       = c;
    r.crc_ok    = ok;
    r.run_end   = 1'b0;
    return r;
  endfunction

  task automatic restart_image();
    blk_fill = 12'd0;
    seq_no   = SEQ_INIT;
    img_crc  = CRC_INIT;
  endtask

  task automatic frame_image_byte(input logic [7:0] d, input logic fin);
    frame_out_t  res [4];
    int          n;
    logic [11:0] chunk;
    logic        closes;
    n = 0;
    chunk = ((blk_len < MIN_BLOCK) ? MIN_BLOCK : blk_len) - HDR_BYTES;
    if (blk_fill == 12'd0) begin
      res[n] = mk_out(SID_TRANSFER, 1'b1, 1'b0, 32'd0, 1'b0);
      n++;
      res[n] = mk_out(seq_no, 1'b0, 1'b0, 32'd0, 1'b0);
      n++;
    end
    img_crc = crc32_update(img_crc, d);
    closes = fin || (({1'b0, blk_fill} + 13'd1) >= {1'b0, chunk});
    res[n] = mk_out(d, 1'b0, closes, 32'd0, 1'b0);
    n++;
    if (closes) begin
      blk_fill = 12'd0;
      seq_no   = seq_no + 8'd1;
    end else begin
      blk_fill = blk_fill + 12'd1;
    end
    if (fin) begin
      res[n] = mk_out(SID_EXIT, 1'b1, 1'b1, img_crc, 1'b1);
      n++;
      restart_image();
    end
    res[n-1].run_end = 1'b1;
    for (int k = 0; k < n; k++) frame_bytes_q.insert(frame_bytes_q.size(), res[k]);
  endtask

  always @(posedge clk) begin : watch
    frame_out_t got;
    frame_out_t want;
    logic       bad;
    if (!rst_n) begin
      blk_len = BLK_LEN_RST;
      restart_image();
      frame_bytes_q.delete();
      fail_cnt = 0;
    end else begin
      if (cfg_wr_en) blk_len = cfg_wr_data;
      if (in_tvalid && in_tready) frame_image_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.octet     = out_tdata[7:0];
        got.crc       = out_tdata[39:8];
        got.frm_last  = out_tlast;
        got.frm_first = out_tuser[0];
        got.crc_ok    = out_tuser[1];
        got.run_end   = out_tuser[2];
        if (frame_bytes_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: unexpected item byte %02h first %b last %b crc %08h ok %b end %b",
                     $realtime, got.octet, got.frm_first, got.frm_last, got.crc,
                     got.crc_ok, got.run_end);
          fail_cnt++;
        end else begin
          want = frame_bytes_q.pop_front();
          bad = (got.octet !== want.octet) || (got.frm_first !== want.frm_first) ||
                (got.frm_last !== want.frm_last) || (got.crc !== want.crc) ||
                (got.crc_ok !== want.crc_ok) || (got.run_end !== want.run_end);
          if (bad) begin
            if (fail_cnt < 10) begin
              $display("%0t: mismatch exp byte %02h first %b last %b crc %08h ok %b end %b",
                       $realtime, want.octet, want.frm_first, want.frm_last, want.crc,
                       want.crc_ok, want.run_end);
              $display("%0t:          got byte %02h first %b last %b crc %08h ok %b end %b",
                       $realtime, got.octet, got.frm_first, got.frm_last, got.crc,
                       got.crc_ok, got.run_end);
            end
            fail_cnt++;
          end
        end
      end
    end
    pending = frame_bytes_q.size();
  end

endmodule

[dv/uds_transfer_data_framer_crc_tb.sv]
// top of the framer testbench: clock, reset, block length writes, image byte stimulus
// and random backpressure; depends on uds_transfer_data_framer_crc and the
// uds_transfer_data_framer_crc_chk checker that predicts and compares
`timescale 1ns / 1ps

module uds_transfer_data_framer_crc_tb;

  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;
  int          fail_cnt;
  int          pending;
  bit          burst;
  bit          long_hold;

  uds_transfer_data_framer_crc DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  uds_transfer_data_framer_crc_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .fail_cnt    (fail_cnt),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic fin);
    int gap;
    gap = burst ? 0 : pick_gap();
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= fin;
    @(posedge clk iff in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_blk_len(input logic [11:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // receiver side
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (burst) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // sender side and verdict
  initial begin
    logic [11:0] settings [8];
    int          n;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 12'd0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'd0;
    in_tlast    = 1'b0;
    burst       = 1'b1;
    long_hold   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // block length from reset, short images and a single byte image
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h36, 1'b0);
    send_byte(8'h37, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h5A, 1'b1);
    drain();
    burst = 1'b0;

    // lengths 0 and 2 act as the minimum of 3, one payload byte per frame; then lengths 3 and 4
    write_blk_len(12'd0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);
    drain();
    write_blk_len(12'd2);
    send_byte(8'hA5, 1'b1);
    drain();
    write_blk_len(12'd3);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h81, 1'b1);
    drain();
    write_blk_len(12'd4);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    send_byte(8'h40, 1'b1);
    drain();

    // shrink the block length while a frame is open
    write_blk_len(12'd20);
    repeat (8) send_byte(8'($urandom_range(0, 255)), 1'b0);
    drain();
    write_blk_len(12'd5);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
    drain();

    // random images over several block lengths
    settings[0] = 12'd4095;
    settings[1] = 12'd3;
    settings[2] = 12'd0;
    settings[3] = 12'd7;
    settings[4] = 12'($urandom_range(3, 40));
    settings[5] = 12'd2;
    settings[6] = 12'd12;
    settings[7] = 12'($urandom_range(0, 4095));
    long_hold = 1'b1;
    for (int p = 0; p < 8; p++) begin
      write_blk_len(settings[p]);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 12; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      drain();
    end

    // one longer image at one payload byte per frame
    write_blk_len(12'd3);
    burst = ($urandom_range(0, 1) == 0);
    n = 40;
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
    drain();
    repeat (10) @(posedge clk);

    if (fail_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
